// ===== hdl/kmer_window_encoder_assert.svh =====
// Assertion macros for the k-mer window encoder.
// Each macro takes a label, a trigger condition and a consequence.
`ifndef KMER_WINDOW_ENCODER_ASSERT_SVH
`define KMER_WINDOW_ENCODER_ASSERT_SVH

`ifndef SYNTH

// Consequence holds in the same cycle as the trigger.
`define KWE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kmer window encoder check failed");

// Consequence holds in the cycle after the trigger.
`define KWE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kmer window encoder check failed");

`else

`define KWE_ASSERT_IMP(lbl, ante, cons)
`define KWE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/kwe_pkg.sv =====
`default_nettype none

package kwe_pkg;

  // Largest window the encoder can hold, in bases
  localparam int unsigned BASE_LIMIT = 32;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned DIST_W     = 6;
  localparam int unsigned KLEN_W     = 6;

  // Two-bit base codes
  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_G = 2'd1;
  localparam logic [1:0] CODE_C = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  // Reset value of the window length register
  localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd32;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_K_LENGTH    = 2'd0,
    CFG_SHIFT_RIGHT = 2'd1,
    CFG_QUERY_KMER  = 2'd2
  } cfg_idx_e;

  // Controls shared by every cell of the row
  typedef struct packed {
    logic       en;
    logic       clear;
    logic       shift_right;
    logic [1:0] code;
  } cell_ctl_t;

  // Where a cell stands relative to the current window length
  typedef struct packed {
    logic in_span;
    logic at_top;
    logic at_bottom;
  } cell_pos_t;

  // One result item
  typedef struct packed {
    logic [WORD_W-1:0] window_code;
    logic [WORD_W-1:0] reverse_complement;
    logic [DIST_W-1:0] distance_to_query;
  } out_item_t;

  // Occupancy of the output buffer
  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } ost_status_t;

  // Map an ASCII nucleotide to its code; anything unknown reads as A
  function automatic logic [1:0] base_code(input logic [7:0] ch);
    logic [1:0] c;
    case (ch)
      8'h47, 8'h67: c = CODE_G;
      8'h43, 8'h63: c = CODE_C;
      8'h54, 8'h74: c = CODE_T;
      default:      c = CODE_A;
    endcase
    return c;
  endfunction

  // Count set bits with a five-level adder tree
  function automatic logic [5:0] popcnt32(input logic [31:0] v);
    logic [1:0] l1 [16];
    logic [2:0] l2 [8];
    logic [3:0] l3 [4];
    logic [4:0] l4 [2];
    for (int i = 0; i < 16; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/kwe_cell.sv =====
`default_nettype none

// One base position of the window: holds its code and its query mismatch flag
module kwe_cell import kwe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctl_t  ctl_i,
  input  wire cell_pos_t  pos_i,
  input  wire logic [1:0] lower_i,
  input  wire logic [1:0] upper_i,
  input  wire logic [1:0] query_i,
  output logic      [1:0] code_o,
  output logic            miss_o
);

  logic [1:0] code_q, code_d;
  logic       miss_q, miss_d;
  logic [1:0] fill;

  // Pick the incoming base: new code at the entry end, else the neighbor (zero on clear); zero outside the span
  always_comb begin
    if (ctl_i.shift_right) begin
      fill = pos_i.at_top ? ctl_i.code : (ctl_i.clear ? 2'b00 : upper_i);
    end else begin
      fill = pos_i.at_bottom ? ctl_i.code : (ctl_i.clear ? 2'b00 : lower_i);
    end
    code_d = pos_i.in_span ? fill : 2'b00;
    miss_d = pos_i.in_span && (code_d != query_i);
  end

  // Advance on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= 2'b00;
      miss_q <= 1'b0;
    end else if (ctl_i.en) begin
      code_q <= code_d;
      miss_q <= miss_d;
    end
  end

  assign code_o = code_q;
  assign miss_o = miss_q;

endmodule

`default_nettype wire

// ===== hdl/kwe_ostage.sv =====
`default_nettype none

// Output register with a skid entry so the row can advance while a result waits
module kwe_ostage import kwe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s1_valid_i,
  input  wire out_item_t   item_i,
  output logic             move_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        item_o,
  output ost_status_t      status_o
);

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t main_q, main_d;
  out_item_t skid_q, skid_d;
  logic      main_free;

  // Fill main first, spill into skid when main is held
  always_comb begin
    main_free    = !main_valid_q || !out_stall_i;
    move_o       = s1_valid_i && !skid_valid_q;
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (main_free) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = item_i;
        main_valid_d = move_o;
      end
    end else if (move_o) begin
      skid_d       = item_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o         = main_valid_q;
  assign item_o              = main_q;
  assign status_o.main_valid = main_valid_q;
  assign status_o.skid_valid = skid_valid_q;

endmodule

`default_nettype wire

// ===== hdl/kmer_window_encoder.sv =====
// The cell row loads at the edge that accepts an item; its result then moves into the output
// register, or into the skid entry while the output register is held by out_stall_i.
// Throughput: one item per cycle while in_stall_o is low; the cell row shifts once per item and
// the skid entry lets it advance while the previous result is stalled.
// Reset (rst_ni low, asynchronous): window cleared, k_length 32, shift_right 0,
// query_kmer 0, no result pending.
`default_nettype none

`include "kmer_window_encoder_assert.svh"

module kmer_window_encoder import kwe_pkg::*; #(
  parameter int unsigned MAX_BASES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  base_char_i,
  input  wire logic        start_new_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      window_code_o,
  output logic [63:0]      reverse_complement_o,
  output logic [5:0]       distance_to_query_o
);

  localparam int unsigned IDX_W = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1;

  logic [KLEN_W-1:0] k_length_q;
  logic              shift_right_q;
  logic [63:0]       query_kmer_q;
  logic [KLEN_W-1:0] k_eff;
  logic              in_accept;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_move;
  cell_ctl_t         ctl;
  logic [1:0]        cell_code [MAX_BASES];
  logic [MAX_BASES-1:0] miss_vec;
  logic [MAX_BASES-1:0] span;
  logic [63:0]       window_w;
  logic [63:0]       rc_w;
  logic [63:0]       span_mask;
  logic              out_in_span;
  out_item_t         s1_item;
  out_item_t         out_item;
  ost_status_t       ost_status;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_length_q    <= KLEN_RESET;
      shift_right_q <= 1'b0;
      query_kmer_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_K_LENGTH:    k_length_q    <= cfg_data_i[KLEN_W-1:0];
        CFG_SHIFT_RIGHT: shift_right_q <= cfg_data_i[0];
        CFG_QUERY_KMER:  query_kmer_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the window length into 1..MAX_BASES
  always_comb begin
    if (k_length_q == '0) begin
      k_eff = KLEN_W'(1);
    end else if (k_length_q > KLEN_W'(MAX_BASES)) begin
      k_eff = KLEN_W'(MAX_BASES);
    end else begin
      k_eff = k_length_q;
    end
  end

  // Stage one is the cell row itself; it holds while the skid entry is full
  assign in_stall_o = s1_valid_q && ost_status.skid_valid;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  assign ctl.en          = in_accept;
  assign ctl.clear       = start_new_i;
  assign ctl.shift_right = shift_right_q;
  assign ctl.code        = base_code(base_char_i);

  // Build the row of cells
  for (genvar i = 0; i < MAX_BASES; i++) begin : g_cell
    logic [1:0] lower;
    logic [1:0] upper;
    cell_pos_t  pos;

    if (i == 0) begin : g_bot
      assign lower = 2'b00;
    end else begin : g_mid_lo
      assign lower = cell_code[i-1];
    end
    if (i == MAX_BASES - 1) begin : g_top
      assign upper = 2'b00;
    end else begin : g_mid_hi
      assign upper = cell_code[i+1];
    end

    assign span[i]       = KLEN_W'(i) < k_eff;
    assign pos.in_span   = span[i];
    assign pos.at_top    = KLEN_W'(i) == (k_eff - KLEN_W'(1));
    assign pos.at_bottom = (i == 0);

    kwe_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .pos_i   (pos),
      .lower_i (lower),
      .upper_i (upper),
      .query_i (query_kmer_q[2*i +: 2]),
      .code_o  (cell_code[i]),
      .miss_o  (miss_vec[i])
    );
  end

  // Gather window, reverse complement and mask from the row
  always_comb begin
    logic [KLEN_W-1:0] src;
    window_w  = '0;
    rc_w      = '0;
    span_mask = '0;
    for (int j = 0; j < MAX_BASES; j++) begin
      src = k_eff - KLEN_W'(1) - KLEN_W'(j);
      window_w[2*j +: 2]  = cell_code[j];
      span_mask[2*j +: 2] = {2{span[j]}};
      if (span[j] && (src < KLEN_W'(MAX_BASES))) begin
        rc_w[2*j +: 2] = ~cell_code[src[IDX_W-1:0]];
      end
    end
  end

  assign s1_item.window_code        = window_w;
  assign s1_item.reverse_complement = rc_w;
  assign s1_item.distance_to_query  = popcnt32(32'(miss_vec));

  kwe_ostage u_ostage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid_q),
    .item_i      (s1_item),
    .move_o      (s1_move),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .item_o      (out_item),
    .status_o    (ost_status)
  );

  assign window_code_o        = out_item.window_code;
  assign reverse_complement_o = out_item.reverse_complement;
  assign distance_to_query_o  = out_item.distance_to_query;

  // Result bits above the window span stay zero
  assign out_in_span = ((window_code_o & ~span_mask) == 64'd0) &&
                       ((reverse_complement_o & ~span_mask) == 64'd0);

  // Checks
  `KWE_ASSERT_IMP(a_skid_needs_main, ost_status.skid_valid, ost_status.main_valid)
  `KWE_ASSERT_IMP(a_out_in_span, out_valid_o, out_in_span)
  `KWE_ASSERT_IMP(a_dist_le_k, out_valid_o, distance_to_query_o <= k_eff)
  `KWE_ASSERT_NXT(a_row_holds, s1_valid_q && in_stall_o, $stable(window_w))

endmodule

`default_nettype wire

// ===== tb/kmer_window_encoder_tb.sv =====
`default_nettype none

// Tracks the rolling k-mer window and holds the results the encoder owes
class kmer_window_tracker;
  logic [5:0]               k_reg;
  logic                     right_mode;
  logic [63:0]              query_code;
  logic [63:0]              window_code;
  kwe_pkg::out_item_t       window_results_q[$];
  int unsigned              fail_count;

  function new();
    k_reg       = kwe_pkg::KLEN_RESET;
    right_mode  = 1'b0;
    query_code  = '0;
    window_code = '0;
    fail_count  = 0;
  endfunction

  // Mirror a register write; indexes past the list are dropped
  function void write_reg(logic [1:0] idx, logic [63:0] data);
    case (idx)
      kwe_pkg::CFG_K_LENGTH:    k_reg = data[5:0];
      kwe_pkg::CFG_SHIFT_RIGHT: right_mode = data[0];
      kwe_pkg::CFG_QUERY_KMER:  query_code = data;
      default: ;
    endcase
  endfunction

  // Shift one accepted base into the window and queue the result it causes
  function void shift_in_base(logic [7:0] ch, logic start);
    int unsigned        k;
    logic [63:0]        span;
    logic [63:0]        w;
    logic [63:0]        diff;
    logic [1:0]         code;
    logic [5:0]         mismatches;
    kwe_pkg::out_item_t want;
    // clamp k into 1..BASE_LIMIT
    if (k_reg == 0) k = 1;
    else if (k_reg > kwe_pkg::BASE_LIMIT) k = kwe_pkg::BASE_LIMIT;
    else k = k_reg;
    span = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
    case (ch)
      "G", "g": code = kwe_pkg::CODE_G;
      "C", "c": code = kwe_pkg::CODE_C;
      "T", "t": code = kwe_pkg::CODE_T;
      default:  code = kwe_pkg::CODE_A;
    endcase
    w = start ? '0 : window_code;
    w &= span;
    if (right_mode) w = (w >> 2) | ({62'd0, code} << (2 * (k - 1)));
    else w = (w << 2) | {62'd0, code};
    w &= span;
    window_code = w;
    want.window_code = w;
    // reverse base order, invert each code
    want.reverse_complement = '0;
    for (int i = 0; i < k; i++)
      want.reverse_complement[2 * (k - 1 - i) +: 2] = ~w[2 * i +: 2];
    // count differing base positions
    diff = (w ^ query_code) & span;
    mismatches = '0;
    for (int i = 0; i < 32; i++)
      if (diff[2 * i +: 2] != 2'b00) mismatches++;
    want.distance_to_query = mismatches;
    window_results_q.push_back(want);
  endfunction

  function void note_failure(string what, logic [63:0] want, logic [63:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%s mismatch: expected %h, got %h", what, want, got);
  endfunction

  // Compare one accepted result against the oldest expectation
  function void check_result(logic [63:0] win, logic [63:0] rc, logic [5:0] got_dist);
    kwe_pkg::out_item_t want;
    if (window_results_q.size() == 0) begin
      note_failure("unexpected result", '0, win);
      return;
    end
    want = window_results_q.pop_front();
    if (win !== want.window_code) note_failure("window_code", want.window_code, win);
    if (rc !== want.reverse_complement)
      note_failure("reverse_complement", want.reverse_complement, rc);
    if (got_dist !== want.distance_to_query)
      note_failure("distance_to_query", {58'd0, want.distance_to_query}, {58'd0, got_dist});
  endfunction

  function int pending();
    return window_results_q.size();
  endfunction

  // Any expectation still queued is a missing result
  function void close_out();
    if (window_results_q.size() != 0) begin
      $display("%0d results never arrived", window_results_q.size());
      fail_count += window_results_q.size();
    end
  endfunction
endclass

module kmer_window_encoder_tb;
  import kwe_pkg::*;

  localparam logic [1:0] CFG_NONE_IDX = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned SETTLE       = 2;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_K_LENGTH;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  base_char_i = '0;
  logic        start_new_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] window_code_o;
  logic [63:0] reverse_complement_o;
  logic [5:0]  distance_to_query_o;

  kmer_window_tracker tracker;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  logic [7:0] opening_chars [12] = '{"A", "G", "C", "T", "a", "g", "c", "t",
                                     "N", 8'h00, 8'hFF, "x"};
  logic [7:0] nucleotides [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};

  kmer_window_encoder dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .base_char_i          (base_char_i),
    .start_new_i          (start_new_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .window_code_o        (window_code_o),
    .reverse_complement_o (reverse_complement_o),
    .distance_to_query_o  (distance_to_query_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Track register writes and accepted items
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) tracker.write_reg(cfg_idx_i, cfg_data_i);
    if (rst_ni && in_valid_i && !in_stall_o) tracker.shift_in_base(base_char_i, start_new_i);
  end

  // Check accepted results
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_result(window_code_o, reverse_complement_o, distance_to_query_o);
  end

  // Drive the result stall: long hold-off on request, random otherwise
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      quiet_cycles <= 0;
    else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Offer one item, with an optional gap first; return at the accepting edge
  task automatic push_base(input logic [7:0] ch, input logic start);
    // idle the sender in the given share of cycles
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    base_char_i <= ch;
    start_new_i <= start;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold input until every result is out, then let the pipeline settle
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write all three registers back to back, optionally one stray index
  task automatic program_regs(input logic [63:0] k, input logic right,
                              input logic [63:0] query, input bit stray);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_K_LENGTH;
    cfg_data_i <= k;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SHIFT_RIGHT;
    cfg_data_i <= {63'd0, right};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_QUERY_KMER;
    cfg_data_i <= query;
    @(posedge clk_i);
    if (stray) begin
      cfg_idx_i  <= CFG_NONE_IDX;
      cfg_data_i <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] pick_k();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 64'd0;
    if (r < 12) return 64'($urandom_range(33, 63));
    if (r < 20) return 64'd32;
    if (r < 25) return 64'd1;
    return 64'($urandom_range(1, 32));
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(99) < 85) return nucleotides[$urandom_range(7)];
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int unsigned sent;
    int unsigned len;
    bit          fresh;
    bit          first_hold;
    bit          second_hold;
    logic [63:0] q;

    tracker     = new();
    sent        = 0;
    first_hold  = 1'b0;
    second_hold = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: k of 32, left shift, all-A query; every code and odd bytes
    foreach (opening_chars[i]) push_base(opening_chars[i], i == 0);

    // k of zero acts as one; stray index must leave the registers alone
    drain_and_settle();
    program_regs(64'd0, 1'b1, {$urandom, $urandom}, 1'b1);
    push_base("T", 1'b0);
    push_base("g", 1'b0);

    // k above the limit acts as 32; all-T query against a fresh all-A window, then one C
    drain_and_settle();
    program_regs(64'd63, 1'b1, '1, 1'b0);
    push_base("A", 1'b1);
    push_base("C", 1'b0);

    // Small window with query bits above 2k, then shrink k mid-stream
    drain_and_settle();
    q = {$urandom, $urandom};
    program_regs(64'd5, 1'b0, q, 1'b0);
    push_base("G", 1'b1);
    push_base("A", 1'b0);
    push_base("T", 1'b0);
    push_base("t", 1'b0);
    push_base("C", 1'b0);
    push_base("a", 1'b0);
    drain_and_settle();
    program_regs(64'd3, 1'b0, q, 1'b0);
    push_base("G", 1'b0);
    push_base("C", 1'b0);

    // Random reads, each phase under fresh settings
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 28;
        recv_idle_pct = 59;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_and_settle();
      q = ($urandom_range(3) == 0) ? 64'd0 : {$urandom, $urandom};
      program_regs(pick_k(), 1'($urandom_range(1)), q, $urandom_range(9) == 0);
      // now and then keep the old window so a change of k cuts it
      fresh = ($urandom_range(7) != 0);
      repeat ($urandom_range(2, 4)) begin
        len = $urandom_range(1, 80);
        for (int j = 0; j < len && sent < RANDOM_ITEMS; j++) begin
          // long result hold-off while items keep coming
          if (!first_hold && sent >= 300) begin
            first_hold = 1'b1;
            hold_req  <= hold_req + 1;
          end
          if (!second_hold && sent >= 1500) begin
            second_hold = 1'b1;
            hold_req   <= hold_req + 1;
          end
          push_base(pick_char(), (j == 0 && fresh) || $urandom_range(29) == 0);
          sent++;
        end
        fresh = 1'b1;
      end
    end

    drain_and_settle();
    tracker.close_out();
    if (tracker.fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
